/* hdl/sopmp_pkg.sv */
// Package for the sum-of-powers block: field widths, modulus constants and shared types.
// Used by sum_of_powers_mod_prime and its checker; depends on nothing else.
package sopmp_pkg;

  localparam int N_W      = 63;
  localparam int K_W      = 6;
  localparam int SUM_W    = 30;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 32;

  localparam logic [29:0] PRIME       = 30'd1000000007;
  localparam logic [30:0] PRIME2      = 31'd2000000014;
  localparam logic [29:0] EXP_INV     = 30'd1000000005;
  localparam logic [30:0] BARRETT_MU  = 31'(64'h1000_0000_0000_0000 / 64'(PRIME));
  localparam logic [29:0] TWO32_MOD   = 30'(64'h1_0000_0000 % 64'(PRIME));

  typedef enum logic [2:0] {
    TAG_INIT = 3'd0,
    TAG_NRED = 3'd1,
    TAG_FALL = 3'd2,
    TAG_COEF = 3'd3,
    TAG_TERM = 3'd4
  } mul_tag_t;

  typedef enum logic [8:0] {
    ST_INV_ISSUE  = 9'b000000001,
    ST_INV_WAIT   = 9'b000000010,
    ST_STIR_READ  = 9'b000000100,
    ST_STIR_ISSUE = 9'b000001000,
    ST_STIR_WAIT  = 9'b000010000,
    ST_IDLE       = 9'b000100000,
    ST_NRED       = 9'b001000000,
    ST_RUN        = 9'b010000000,
    ST_DONE       = 9'b100000000
  } state_t;

endpackage

/* hdl/sum_of_powers_mod_prime.sv */
// Top level: sum of i^k for i = 1..n modulo 1000000007 by the Stirling form of Faulhaber.
// Holds the Stirling and inverse memories and one shared four-stage modular multiplier.
// Depends on sopmp_pkg.
// Each j of the sum is paced by the falling factorial chain through the four-stage multiplier.
// One query is in flight at a time; the result register lets the next query in while a
// result waits.
// After reset the block fills its inverse table and then its Stirling table before it takes
// any beat.
module sum_of_powers_mod_prime #(
  parameter int MAX_POWER = 63
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sopmp_pkg::S_DATA_W-1:0] s_axis_tdata,  // count_n[62:0], power_k[68:63]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sopmp_pkg::M_DATA_W-1:0] m_axis_tdata   // power_sum[29:0]
);
  import sopmp_pkg::*;

  localparam int D          = MAX_POWER + 1;
  localparam int STIR_DEPTH = D * D;
  localparam int SAW        = $clog2(STIR_DEPTH);
  localparam int INV_DEPTH  = MAX_POWER + 2;
  localparam int IAW        = $clog2(INV_DEPTH);
  localparam int RW         = $clog2(MAX_POWER + 1) > 0 ? $clog2(MAX_POWER + 1) : 1;

  state_t state;

  logic [SUM_W-1:0] stir_mem [STIR_DEPTH];
  logic [SUM_W-1:0] inv_mem  [INV_DEPTH];
  logic             stir_we;
  logic [SAW-1:0]   stir_waddr;
  logic [SUM_W-1:0] stir_wdata;
  logic [SAW-1:0]   stir_raddr_a;
  logic [SAW-1:0]   stir_raddr_b;
  logic [SUM_W-1:0] stir_rd_a;
  logic [SUM_W-1:0] stir_rd_b;
  logic             inv_we;
  logic [IAW-1:0]   inv_raddr;
  logic [SUM_W-1:0] inv_rd;

  logic             mul_go;
  logic [30:0]      mul_a;
  logic [29:0]      mul_b;
  logic [31:0]      mul_c;
  mul_tag_t         mul_tag;
  logic [60:0]      mul_prod;
  logic             v1, v2, v3, mo_valid;
  mul_tag_t         t1, t2, t3, mo_tag;
  logic [59:0]      p1;
  logic [30:0]      q2;
  logic [31:0]      lo2;
  logic [31:0]      qp3;
  logic [31:0]      r3;
  logic [SUM_W-1:0] mo_res;

  logic [IAW-1:0]   inv_idx;
  logic [4:0]       inv_bit;
  logic             inv_half;
  logic [SUM_W-1:0] inv_acc;
  logic [RW-1:0]    si;
  logic [RW-1:0]    sj;

  logic [K_W-1:0]   k_reg;
  logic [IAW-1:0]   j;
  logic [2:0]       phase;
  logic [SUM_W-1:0] factor;
  logic [SUM_W-1:0] fall;
  logic [SUM_W-1:0] coef;
  logic [SUM_W-1:0] acc;
  logic [30:0]      acc_sum;
  logic             j_le_k;
  logic             j_last;
  logic             s_fire;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign j_le_k        = 32'(j) <= 32'(k_reg);
  assign j_last        = 32'(j) == 32'(k_reg) + 32'd1;
  assign acc_sum       = 31'(acc) + 31'(mo_res);

  always_ff @(posedge clk) begin
    if (stir_we) begin
      stir_mem[stir_waddr] <= stir_wdata;
    end
    stir_rd_a <= stir_mem[stir_raddr_a];
    stir_rd_b <= stir_mem[stir_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (inv_we) begin
      inv_mem[inv_idx] <= mo_res;
    end
    inv_rd <= inv_mem[inv_raddr];
  end

  always_comb begin
    inv_we       = (state == ST_INV_WAIT) && mo_valid && inv_half && (inv_bit == 5'd0);
    inv_raddr    = IAW'(32'(j) + 32'd1);
    stir_we      = 1'b0;
    stir_wdata   = mo_res;
    stir_waddr   = SAW'(int'(si) * D + int'(sj));
    stir_raddr_b = SAW'((int'(si) - 1) * D + int'(sj) - 1);
    if (state == ST_RUN) begin
      stir_raddr_a = SAW'(int'(k_reg) * D + int'(j));
    end else begin
      stir_raddr_a = SAW'((int'(si) - 1) * D + int'(sj));
    end
    if (state == ST_STIR_READ && (si == '0 || sj == '0)) begin
      stir_we    = 1'b1;
      stir_wdata = (si == '0) ? SUM_W'(1) : '0;
    end else if (state == ST_STIR_WAIT && mo_valid) begin
      stir_we = 1'b1;
    end
  end

  always_comb begin
    mul_go  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    mul_c   = '0;
    mul_tag = TAG_INIT;
    unique case (state)
      ST_INV_ISSUE: begin
        mul_go = 1'b1;
        mul_a  = 31'(inv_acc);
        if (!inv_half) begin
          mul_b = inv_acc;
        end else begin
          mul_b = EXP_INV[inv_bit] ? 30'(inv_idx) : 30'd1;
        end
      end
      ST_STIR_ISSUE: begin
        mul_go = 1'b1;
        mul_a  = 31'(sj);
        mul_b  = (sj == si) ? '0 : stir_rd_a;
        mul_c  = 32'(stir_rd_b);
      end
      ST_IDLE: begin
        mul_go  = s_fire;
        mul_tag = TAG_NRED;
        mul_a   = s_axis_tdata[62:32];
        mul_b   = TWO32_MOD;
        mul_c   = s_axis_tdata[31:0];
      end
      ST_RUN: begin
        if (phase == 3'd0 && j_le_k) begin
          mul_go  = 1'b1;
          mul_tag = TAG_FALL;
          mul_a   = 31'(fall);
          mul_b   = factor;
        end else if (phase == 3'd1 && j_le_k) begin
          mul_go  = 1'b1;
          mul_tag = TAG_COEF;
          mul_a   = 31'(stir_rd_a);
          mul_b   = inv_rd;
        end else if (phase == 3'd2 && j != '0) begin
          mul_go  = 1'b1;
          mul_tag = TAG_TERM;
          mul_a   = 31'(coef);
          mul_b   = fall;
        end
      end
      default: begin
      end
    endcase
  end

  // Modular multiplier: product plus addend, then Barrett reduction over three more stages.
  assign mul_prod = 61'(mul_a) * 61'(mul_b) + 61'(mul_c);
  assign qp3      = 32'(64'(q2) * 64'(PRIME));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      mo_valid <= 1'b0;
    end else begin
      v1       <= mul_go;
      v2       <= v1;
      v3       <= v2;
      mo_valid <= v3;
    end
    t1     <= mul_tag;
    t2     <= t1;
    t3     <= t2;
    mo_tag <= t3;
    p1     <= mul_prod[59:0];
    q2     <= 31'((62'(p1[59:29]) * 62'(BARRETT_MU)) >> 31);
    lo2    <= p1[31:0];
    r3     <= lo2 - qp3;
    if (r3 >= 32'(PRIME2)) begin
      mo_res <= 30'(r3 - 32'(PRIME2));
    end else if (r3 >= 32'(PRIME)) begin
      mo_res <= 30'(r3 - 32'(PRIME));
    end else begin
      mo_res <= 30'(r3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INV_ISSUE;
      inv_idx       <= '0;
      inv_bit       <= 5'd29;
      inv_half      <= 1'b0;
      inv_acc       <= SUM_W'(1);
      si            <= '0;
      sj            <= '0;
      j             <= '0;
      phase         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_INV_ISSUE: begin
          state <= ST_INV_WAIT;
        end
        ST_INV_WAIT: begin
          if (mo_valid) begin
            inv_acc <= mo_res;
            state   <= ST_INV_ISSUE;
            if (!inv_half) begin
              inv_half <= 1'b1;
            end else begin
              inv_half <= 1'b0;
              if (inv_bit == 5'd0) begin
                inv_acc <= SUM_W'(1);
                inv_bit <= 5'd29;
                if (32'(inv_idx) == 32'(INV_DEPTH - 1)) begin
                  state <= ST_STIR_READ;
                end else begin
                  inv_idx <= inv_idx + IAW'(1);
                end
              end else begin
                inv_bit <= inv_bit - 5'd1;
              end
            end
          end
        end
        ST_STIR_READ, ST_STIR_WAIT: begin
          if ((state == ST_STIR_READ && si != '0 && sj != '0)) begin
            state <= ST_STIR_ISSUE;
          end else if (state == ST_STIR_READ || mo_valid) begin
            state <= ST_STIR_READ;
            if (sj == si) begin
              if (32'(si) == 32'(MAX_POWER)) begin
                state <= ST_IDLE;
              end else begin
                si <= si + RW'(1);
                sj <= '0;
              end
            end else begin
              sj <= sj + RW'(1);
            end
          end
        end
        ST_STIR_ISSUE: begin
          state <= ST_STIR_WAIT;
        end
        ST_IDLE: begin
          if (s_fire) begin
            k_reg <= s_axis_tdata[68:63];
            state <= ST_NRED;
          end
        end
        ST_NRED: begin
          if (mo_valid) begin
            j      <= '0;
            phase  <= '0;
            fall   <= SUM_W'(1);
            factor <= (mo_res == PRIME - 30'd1) ? '0 : mo_res + 30'd1;
            if (k_reg == '0) begin
              acc   <= mo_res;
              state <= ST_DONE;
            end else if (32'(k_reg) > 32'(MAX_POWER)) begin
              acc   <= '0;
              state <= ST_DONE;
            end else begin
              acc   <= '0;
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (phase == 3'd0 && j_le_k) begin
            factor <= (factor == '0) ? PRIME - 30'd1 : factor - 30'd1;
          end
          if (mo_valid) begin
            case (mo_tag)
              TAG_FALL: fall <= mo_res;
              TAG_COEF: coef <= mo_res;
              TAG_TERM: acc  <= (acc_sum >= 31'(PRIME)) ? 30'(acc_sum - 31'(PRIME))
                                                         : 30'(acc_sum);
              default: begin
              end
            endcase
          end
          if (j_last && phase == 3'd6) begin
            state <= ST_DONE;
          end else if (!j_last && phase == 3'd4) begin
            phase <= '0;
            j     <= j + IAW'(1);
          end else begin
            phase <= phase + 3'd1;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00, acc};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_INV_ISSUE;
        end
      endcase
    end
  end

endmodule

/* hdl/sopmp_checker.sv */
// Port-level checker for sum_of_powers_mod_prime, attached by the bind at the end of this file.
// Depends on sopmp_pkg.
module sopmp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [sopmp_pkg::S_DATA_W-1:0] s_axis_tdata,   // count_n[62:0], power_k[68:63]
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sopmp_pkg::M_DATA_W-1:0] m_axis_tdata    // power_sum[29:0]
);
  import sopmp_pkg::*;

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[29:0] < PRIME) && (m_axis_tdata[31:30] == 2'b00))
    else $error("result beat is not reduced modulo the prime");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready while a query is in work");

  a_init_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("block ready or valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

endmodule

bind sum_of_powers_mod_prime sopmp_checker u_sopmp_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

/* bench/sum_of_powers_mod_prime_test.sv */
// Testbench for sum_of_powers_mod_prime: random and directed (n, k) queries checked against
// a local Stirling-form predictor of the power sum modulo 1000000007.
// Depends on sopmp_pkg and the RTL of the block.
module sum_of_powers_mod_prime_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sopmp_pkg::*;

  localparam int MAXK = 63;
  localparam longint unsigned P = 64'd1000000007;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [K_W-1:0] power_k;
    logic [N_W-1:0] count_n;
  } query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  sum_of_powers_mod_prime dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  longint unsigned stir [0:MAXK][0:MAXK];
  longint unsigned inv_of [0:MAXK+1];
  query_t pending_queries[$];
  logic [SUM_W-1:0] expected_sums[$];
  int mismatches = 0;
  int results_seen = 0;
  int accepted = 0;
  int idle_cycles = 0;
  int cycle = 0;
  bit in_accepted = 1'b0;

  function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b);
    return (a % P) * (b % P) % P;
  endfunction

  function automatic longint unsigned powmod(longint unsigned b, longint unsigned e);
    longint unsigned acc;
    acc = 1;
    b = b % P;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, b);
      b = mulmod(b, b);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [SUM_W-1:0] power_sum_of(query_t q);
    longint unsigned n, acc, fall, term;
    int k;
    n = 64'(q.count_n) % P;
    k = int'(q.power_k);
    if (k == 0) return SUM_W'(n);
    acc = 0;
    fall = 1;
    for (int j = 0; j <= k; j++) begin
      fall = mulmod(fall, (n + 1 + P - j) % P);
      term = mulmod(mulmod(stir[k][j], fall), inv_of[j + 1]);
      acc = (acc + term) % P;
    end
    return SUM_W'(acc);
  endfunction

  // Idling is switched off for a long stretch in the middle of the run.
  function automatic bit idle_now();
    if (cycle > 60000 && cycle < 90000) return 1'b0;
    return $urandom_range(99) < 22;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_accepted) begin
        if (pending_queries.size() != 0 && !idle_now()) begin
          s_axis_tdata <= S_DATA_W'(pending_queries.pop_front());
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    query_t q;
    logic [SUM_W-1:0] want;
    cycle <= cycle + 1;
    in_accepted <= s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        q = query_t'(s_axis_tdata[N_W+K_W-1:0]);
        expected_sums.push_back(power_sum_of(q));
        accepted <= accepted + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (expected_sums.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %0d", m_axis_tdata[SUM_W-1:0]);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_sums.pop_front();
          if (m_axis_tdata[SUM_W-1:0] !== want || m_axis_tdata[M_DATA_W-1:SUM_W] !== '0) begin
            if (mismatches < 10)
              $display("power_sum mismatch: expected %0d, got %0d", want, m_axis_tdata);
            mismatches <= mismatches + 1;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("timeout with %0d results outstanding", expected_sums.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic query_t make_query(longint unsigned n, int k);
    query_t q;
    q.count_n = N_W'(n);
    q.power_k = K_W'(k);
    return q;
  endfunction

  initial begin
    longint unsigned n;
    int k;
    for (int i = 0; i <= MAXK + 1; i++) inv_of[i] = powmod(i, P - 2);
    for (int i = 0; i <= MAXK; i++)
      for (int j = 0; j <= MAXK; j++) stir[i][j] = 0;
    stir[0][0] = 1;
    for (int i = 1; i <= MAXK; i++)
      for (int j = 1; j <= i; j++)
        stir[i][j] = (stir[i-1][j] * j + stir[i-1][j-1]) % P;

    pending_queries.push_back(make_query(0, 0));
    pending_queries.push_back(make_query(64'h7FFF_FFFF_FFFF_FFFF, 0));
    pending_queries.push_back(make_query(0, MAXK));
    pending_queries.push_back(make_query(64'h7FFF_FFFF_FFFF_FFFF, MAXK));
    pending_queries.push_back(make_query(1, 1));
    pending_queries.push_back(make_query(10, 2));
    pending_queries.push_back(make_query(P, 3));
    pending_queries.push_back(make_query(P * 5, 17));
    pending_queries.push_back(make_query(P - 1, 5));
    pending_queries.push_back(make_query(P - 2, 40));
    pending_queries.push_back(make_query(P + 1, 0));
    pending_queries.push_back(make_query(3, 10));
    pending_queries.push_back(make_query(20, 63));
    pending_queries.push_back(make_query(62, 63));
    pending_queries.push_back(make_query(64'h5555_5555_5555_5555, 42));
    pending_queries.push_back(make_query(64'h2AAA_AAAA_AAAA_AAAA, 21));
    for (int i = 0; i < 1650; i++) begin
      case ($urandom_range(5))
        0: n = $urandom_range(70);
        1: n = P * $urandom_range(1000) + $urandom_range(3) - 1;
        2: n = $urandom;
        default: n = {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF;
      endcase
      k = ($urandom_range(9) == 0) ? MAXK : $urandom_range(MAXK);
      pending_queries.push_back(make_query(n, k));
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (pending_queries.size() == 0 && !s_axis_tvalid);
    wait (expected_sums.size() == 0);
    repeat (400) @(posedge clk);
    $display("Checked %0d power-sum queries (%0d results), powers 0..%0d and large counts.",
             accepted, results_seen, MAXK);
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
hdl/sopmp_pkg.sv
hdl/sum_of_powers_mod_prime.sv
hdl/sopmp_checker.sv
bench/sum_of_powers_mod_prime_test.sv
